// ----- design/min_tracking_stack_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the min tracking stack
// Each macro expects clk and arst_n in scope and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// A condition that must hold at every clock edge.
`define MTS_ASSERT_HOLD(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define MTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// Min tracking stack package
// Command and result word types, command and status codes, default sizes.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_DATA_WIDTH  = 32;
	localparam int FIELD_W         = 32;
	localparam int DEPTH_FIELD_W   = 7;

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	typedef struct packed {
		logic [1:0]                command;
		logic signed [FIELD_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] top_value;
		logic signed [FIELD_W-1:0] min_value;
		logic [DEPTH_FIELD_W-1:0]  depth_used;
		logic                      is_empty;
		logic [1:0]                status;
	} result_t;

	// Shift control shared by every level of the stack.
	typedef struct packed {
		logic push;
		logic pop;
	} shift_t;

endpackage

// ----- design/mts_cell.sv -----
// ----------------------------------------------------------------------------
// Min tracking stack level
// Holds one value and the minimum at or below it. On a push it takes the
// level above, on a pop it takes the level below, otherwise it holds.
// ----------------------------------------------------------------------------
module mts_cell #(
	parameter int DATA_WIDTH = mts_pkg::DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  mts_pkg::shift_t       ctl,
	input  logic [DATA_WIDTH-1:0] up_value,
	input  logic [DATA_WIDTH-1:0] up_min,
	input  logic [DATA_WIDTH-1:0] down_value,
	input  logic [DATA_WIDTH-1:0] down_min,
	output logic [DATA_WIDTH-1:0] value,
	output logic [DATA_WIDTH-1:0] min_val
);
	import mts_pkg::*;

	logic [DATA_WIDTH-1:0] value_q;
	logic [DATA_WIDTH-1:0] min_q;

	always_ff @(posedge clk) begin
		priority if (ctl.push) begin
			value_q <= up_value;
			min_q   <= up_min;
		end else if (ctl.pop) begin
			value_q <= down_value;
			min_q   <= down_min;
		end else begin
			value_q <= value_q;
			min_q   <= min_q;
		end
	end

	assign value   = value_q;
	assign min_val = min_q;

endmodule

// ----- design/min_tracking_stack.sv -----
// ----------------------------------------------------------------------------
// Min tracking stack: one result word in the cycle after each command word.
// A new command word is taken every cycle; busy never rises, as every level
// shifts together. Reset empties the stack; stored levels are not cleared.
// ----------------------------------------------------------------------------
`include "min_tracking_stack_macros.svh"

module min_tracking_stack #(
	parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
	parameter int DATA_WIDTH  = mts_pkg::DEF_DATA_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mts_pkg::cmd_t    cmd,
	output logic             done,
	output mts_pkg::result_t result
);
	import mts_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [1:0]            status_d;
	shift_t                ctl;
	logic                  full;
	logic                  empty;
	logic signed [63:0]    in_wide;
	logic [DATA_WIDTH-1:0] new_value;
	logic [DATA_WIDTH-1:0] new_min;
	logic [63:0]           top_wide;
	logic [63:0]           min_wide;
	logic [63:0]           cnt_wide;

	logic [DATA_WIDTH-1:0] cell_value [STACK_DEPTH];
	logic [DATA_WIDTH-1:0] cell_min   [STACK_DEPTH];

	assign busy  = 1'b0;
	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(STACK_DEPTH));

	always_comb begin
		ctl      = '0;
		status_d = ST_OK;
		count_d  = count_q;
		if (start) begin
			unique case (cmd.command)
				CMD_PUSH: begin
					if (full) begin
						status_d = ST_OVERFLOW;
					end else begin
						ctl.push = 1'b1;
						count_d  = count_q + CNT_W'(1);
					end
				end
				CMD_POP: begin
					if (empty) begin
						status_d = ST_UNDERFLOW;
					end else begin
						ctl.pop = 1'b1;
						count_d = count_q - CNT_W'(1);
					end
				end
				default: begin
					// Read and the unused code change nothing.
				end
			endcase
		end
	end

	// The incoming word is sign-extended, then cut to the stored width.
	assign in_wide   = 64'(cmd.value);
	assign new_value = in_wide[DATA_WIDTH-1:0];
	assign new_min   = (empty || ($signed(new_value) <= $signed(cell_min[0])))
		? new_value : cell_min[0];

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_level
		logic [DATA_WIDTH-1:0] up_v;
		logic [DATA_WIDTH-1:0] up_m;
		logic [DATA_WIDTH-1:0] dn_v;
		logic [DATA_WIDTH-1:0] dn_m;

		if (i == 0) begin : g_head
			assign up_v = new_value;
			assign up_m = new_min;
		end else begin : g_body
			assign up_v = cell_value[i-1];
			assign up_m = cell_min[i-1];
		end

		// The bottom level is never read after a pop that empties it from below.
		if (i == STACK_DEPTH - 1) begin : g_tail
			assign dn_v = cell_value[i];
			assign dn_m = cell_min[i];
		end else begin : g_inner
			assign dn_v = cell_value[i+1];
			assign dn_m = cell_min[i+1];
		end

		mts_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.up_value  (up_v),
			.up_min    (up_m),
			.down_value(dn_v),
			.down_min  (dn_m),
			.value     (cell_value[i]),
			.min_val   (cell_min[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			count_q  <= count_d;
			done_q   <= start;
			if (start) begin
				status_q <= status_d;
			end
		end
	end

	// The levels and count are the result registers; outputs are masked copies.
	assign top_wide = 64'(cell_value[0]);
	assign min_wide = 64'(cell_min[0]);
	assign cnt_wide = 64'(count_q);

	assign done              = done_q;
	assign result.top_value  = empty ? '0 : top_wide[FIELD_W-1:0];
	assign result.min_value  = empty ? '0 : min_wide[FIELD_W-1:0];
	assign result.depth_used = cnt_wide[DEPTH_FIELD_W-1:0];
	assign result.is_empty   = empty;
	assign result.status     = status_q;

	`MTS_ASSERT_HOLD(a_count_bound, count_q <= CNT_W'(STACK_DEPTH), "count beyond stack depth")
	`MTS_ASSERT_NEXT(a_one_word, start && !busy, done, "command word without result word")
	`MTS_ASSERT_IMP(a_min_order, done && !empty, $signed(cell_min[0]) <= $signed(cell_value[0]), "minimum above top value")
	`MTS_ASSERT_IMP(a_overflow_full, done && status_q == ST_OVERFLOW, full, "overflow flagged while not full")

endmodule

// ----- test/min_stack_monitor.sv -----
// ----------------------------------------------------------------------------
// Min tracking stack monitor
// Watches the command and result channels of the stack, keeps its own copy of
// the levels and the running minimum, and compares every result word in order.
// ----------------------------------------------------------------------------
module min_stack_monitor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  mts_pkg::cmd_t    cmd,
	input  logic             done,
	input  mts_pkg::result_t result,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import mts_pkg::*;

	localparam int LEVELS = DEF_STACK_DEPTH;

	logic signed [FIELD_W-1:0] level_value [LEVELS];
	logic signed [FIELD_W-1:0] level_min   [LEVELS];
	int                        held;
	result_t                   expected_words [$];

	// Applies one command word to the shadow stack and returns the word that
	// the block should answer with.
	function automatic result_t apply_command(cmd_t c);
		result_t r;
		r = '0;
		r.status = ST_OK;
		case (c.command)
			CMD_PUSH: begin
				if (held == LEVELS) begin
					r.status = ST_OVERFLOW;
				end else begin
					level_value[held] = c.value;
					if (held > 0 && $signed(level_min[held-1]) < $signed(c.value))
						level_min[held] = level_min[held-1];
					else
						level_min[held] = c.value;
					held++;
				end
			end
			CMD_POP: begin
				if (held == 0)
					r.status = ST_UNDERFLOW;
				else
					held--;
			end
			// Read and the unused code leave the stack alone.
			default: ;
		endcase
		if (held > 0) begin
			r.top_value = level_value[held-1];
			r.min_value = level_min[held-1];
		end
		r.is_empty   = (held == 0);
		r.depth_used = DEPTH_FIELD_W'(held);
		return r;
	endfunction

	task automatic flag_field(string field, logic [FIELD_W-1:0] want,
			logic [FIELD_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t next_word;
		if (!arst_n) begin
			held = 0;
			expected_words.delete();
		end else begin
			// The expectation goes in first, so a same-cycle answer would still match.
			if (start && !busy) begin
				next_word      = apply_command(cmd);
				expected_words = {expected_words, next_word};
			end
			if (done) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %p",
						$time, result);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					flag_field("top_value", want.top_value, result.top_value);
					flag_field("min_value", want.min_value, result.min_value);
					flag_field("depth_used", FIELD_W'(want.depth_used),
						FIELD_W'(result.depth_used));
					flag_field("is_empty", FIELD_W'(want.is_empty),
						FIELD_W'(result.is_empty));
					flag_field("status", FIELD_W'(want.status), FIELD_W'(result.status));
				end
			end
		end
		pending = expected_words.size();
	end

endmodule

// ----- test/min_tracking_stack_tb.sv -----
// ----------------------------------------------------------------------------
// Min tracking stack testbench
// Drives directed and random push, pop and read words in bursts with random
// gaps; the monitor beside the block predicts and checks every result word.
// ----------------------------------------------------------------------------
module min_tracking_stack_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mts_pkg::*;

	// The fourth command code is not in the package; the block treats it as a read.
	localparam logic [1:0] CMD_SPARE    = 2'd3;
	localparam int         RANDOM_WORDS = 1950;
	localparam int         IDLE_LIMIT   = 2000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;
	int      fail_count;
	int      pending;

	min_tracking_stack DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	min_stack_monitor monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Holds one word on the command port until the block takes it.
	task automatic issue(logic [1:0] op, logic [FIELD_W-1:0] v);
		@(negedge clk);
		start   <= 1'b1;
		cmd     <= '{command: op, value: v};
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Mixes the extremes and a narrow band, so equal minimums come up often.
	function automatic logic [FIELD_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return {1'b1, {(FIELD_W-1){1'b0}}};
			1:       return {1'b0, {(FIELD_W-1){1'b1}}};
			2, 3, 4: return FIELD_W'($signed($urandom_range(0, 16)) - 8);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] pick_command(int push_pct);
		if ($urandom_range(0, 99) < push_pct)
			return CMD_PUSH;
		case ($urandom_range(0, 9))
			0:       return CMD_SPARE;
			1, 2:    return CMD_READ;
			default: return CMD_POP;
		endcase
	endfunction

	initial begin
		int sent;
		int burst_left;
		int push_pct;
		int run_len;
		start  = 1'b0;
		cmd    = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words: empty stack, extremes, equal minimums, unused code.
		issue(CMD_READ, 32'h0000_0000);
		issue(CMD_SPARE, 32'hFFFF_FFFF);
		issue(CMD_POP, 32'h1234_5678);
		issue(CMD_PUSH, 32'h7FFF_FFFF);
		issue(CMD_PUSH, 32'h8000_0000);
		issue(CMD_PUSH, 32'h0000_0000);
		issue(CMD_PUSH, 32'h8000_0000);
		issue(CMD_READ, 32'hFFFF_FFFF);
		issue(CMD_POP, 32'h0000_0000);
		issue(CMD_POP, 32'h0000_0000);
		issue(CMD_POP, 32'h0000_0000);
		issue(CMD_POP, 32'h0000_0000);
		issue(CMD_POP, 32'h0000_0000);
		issue(CMD_PUSH, 32'hFFFF_FFFB);
		issue(CMD_PUSH, 32'h0000_0003);
		issue(CMD_PUSH, 32'hFFFF_FFFB);
		issue(CMD_PUSH, 32'hFFFF_FFFA);
		issue(CMD_SPARE, 32'h8000_0000);
		issue(CMD_POP, 32'h7FFF_FFFF);
		issue(CMD_READ, 32'h5555_AAAA);
		issue(CMD_POP, 32'hAAAA_5555);

		// Random runs lean toward filling, churning or draining the stack, so
		// both the full and the empty edges are reached many times.
		sent       = 0;
		burst_left = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 2))
				0:       push_pct = 85;
				1:       push_pct = 50;
				default: push_pct = 15;
			endcase
			run_len = $urandom_range(20, 150);
			repeat (run_len) begin
				if (burst_left == 0) begin
					pause($urandom_range(0, 6));
					burst_left = $urandom_range(1, 40);
				end
				issue(pick_command(push_pct), pick_value());
				burst_left--;
				sent++;
			end
		end
		@(negedge clk);
		start <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (4) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("min_tracking_stack regression: pass");
		else
			$display("min_tracking_stack regression: fail");
		$finish;
	end

	// Ends the run if neither a command nor a result word moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("min_tracking_stack regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/mts_pkg.sv
design/mts_cell.sv
design/min_tracking_stack.sv
test/min_stack_monitor.sv
test/min_tracking_stack_tb.sv
